>>> hdl/dru_pkg.sv
// dru_pkg: shared types and codes for the descriptor range lookup
// used by dru_cell and descriptor_range_lookup; no dependencies
`default_nettype none
package dru_pkg;

    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [2:0]  VIS_ALL    = 3'd0;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // query payload with the two running matches, handed cell to cell
    typedef struct packed {
        logic [2:0]  vis;
        logic [1:0]  rkind;
        logic [31:0] reg_num;
        logic [31:0] space;
        logic        ex_hit;
        logic [5:0]  ex_owner;
        logic [31:0] ex_off;
        logic        al_hit;
        logic [5:0]  al_owner;
        logic [31:0] al_off;
    } tok_t;

    // one stored range
    typedef struct packed {
        logic [5:0]  owner;
        logic [2:0]  vis;
        logic [1:0]  rkind;
        logic [31:0] base;
        logic [31:0] space;
        logic [31:0] count;
        logic [31:0] offset;
    } entry_t;

endpackage
`default_nettype wire

>>> hdl/dru_cell.sv
// dru_cell: one table slot plus one stage of the query chain
// depends on dru_pkg
`default_nettype none
module dru_cell
    import dru_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire entry_t wr_entry,
    input  wire logic   slot_used,
    input  wire logic   tok_in_active,
    input  wire tok_t   tok_in,
    output logic        tok_out_active,
    output tok_t        tok_out
);

    entry_t      entry_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        active_reg;
    logic [31:0] rel;
    logic        win_hit;

    always_comb
    begin
        rel     = tok_in.reg_num - entry_reg.base;
        win_hit = slot_used && (entry_reg.rkind == tok_in.rkind)
                  && (entry_reg.space == tok_in.space)
                  && (tok_in.reg_num >= entry_reg.base)
                  && ((entry_reg.count == ALL_ONES32) || (rel < entry_reg.count));
        tok_next = tok_in;
        // first exact-visibility match wins
        if (win_hit && !tok_in.ex_hit && (entry_reg.vis == tok_in.vis))
        begin
            tok_next.ex_hit   = 1'b1;
            tok_next.ex_owner = entry_reg.owner;
            tok_next.ex_off   = entry_reg.offset + rel;
        end
        // first all-stages match kept as fallback
        if (win_hit && !tok_in.al_hit && (entry_reg.vis == VIS_ALL))
        begin
            tok_next.al_hit   = 1'b1;
            tok_next.al_owner = entry_reg.owner;
            tok_next.al_off   = entry_reg.offset + rel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= tok_in_active;
        end
    end

    assign tok_out_active = active_reg;
    assign tok_out        = tok_reg;

endmodule
`default_nettype wire

>>> hdl/descriptor_range_lookup.sv
// latency: clear, load and unused kinds give their beat 1 cycle after acceptance
// query: TABLE_DEPTH + 2 cycles, set by the query walking the cell chain one slot a cycle
// throughput: one item at a time, next beat accepted once the result beat is taken
// reset: table count and append offset clear at once; slots stay undefined until loaded
// no clearing pass: a slot at or above the fill count is never matched
`default_nettype none
module descriptor_range_lookup
    import dru_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_OWNERS  = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic        new_table,
    input  wire logic [5:0]  owner_index,
    input  wire logic [2:0]  visibility,
    input  wire logic [1:0]  range_kind,
    input  wire logic [31:0] register_number,
    input  wire logic [31:0] reg_space,
    input  wire logic [31:0] descriptor_count,
    input  wire logic [31:0] table_offset_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic             table_full,
    output logic [5:0]       match_owner,
    output logic [31:0]      desc_offset
);

    localparam int UW = $clog2(TABLE_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [UW-1:0] used_reg, used_next;
    logic [31:0]   append_reg, append_next;
    logic          out_valid_reg, out_valid_next;
    logic          found_reg, found_next;
    logic          full_reg, full_next;
    logic [5:0]    owner_reg, owner_next;
    logic [31:0]   off_reg, off_next;
    logic          inject_reg, inject_next;
    tok_t          inject_tok_reg;

    logic          accept;
    kind_t         in_kind;
    logic [31:0]   start_off, load_off;
    logic          drop;
    logic          load_wr;
    entry_t        wr_entry;

    // chain taps: index i feeds cell i
    logic          chain_active [TABLE_DEPTH+1];
    tok_t          chain_tok    [TABLE_DEPTH+1];

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign in_kind  = kind_t'(kind);

    // offset resolution for a load beat
    assign start_off = new_table ? 32'd0 : append_reg;
    assign load_off  = (table_offset_in == ALL_ONES32) ? start_off : table_offset_in;
    assign drop      = (used_reg == UW'(TABLE_DEPTH))
                       || ({1'b0, owner_index} >= 7'(MAX_OWNERS));
    assign load_wr   = accept && (in_kind == KIND_LOAD) && !drop;

    always_comb
    begin
        wr_entry.owner  = owner_index;
        wr_entry.vis    = visibility;
        wr_entry.rkind  = range_kind;
        wr_entry.base   = register_number;
        wr_entry.space  = reg_space;
        wr_entry.count  = descriptor_count;
        wr_entry.offset = load_off;
    end

    assign chain_active[0] = inject_reg;
    assign chain_tok[0]    = inject_tok_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        dru_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .wr_en          (load_wr && (used_reg == UW'(i))),
            .wr_entry       (wr_entry),
            .slot_used      (UW'(i) < used_reg),
            .tok_in_active  (chain_active[i]),
            .tok_in         (chain_tok[i]),
            .tok_out_active (chain_active[i+1]),
            .tok_out        (chain_tok[i+1])
        );
    end

    // query payload enters cell 0 the cycle after acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inject_tok_reg.vis      <= visibility;
            inject_tok_reg.rkind    <= range_kind;
            inject_tok_reg.reg_num  <= register_number;
            inject_tok_reg.space    <= reg_space;
            inject_tok_reg.ex_hit   <= 1'b0;
            inject_tok_reg.ex_owner <= 6'd0;
            inject_tok_reg.ex_off   <= 32'd0;
            inject_tok_reg.al_hit   <= 1'b0;
            inject_tok_reg.al_owner <= 6'd0;
            inject_tok_reg.al_off   <= 32'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        append_next    = append_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        owner_next     = owner_reg;
        off_next       = off_reg;
        inject_next    = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    owner_next = 6'd0;
                    off_next   = 32'd0;
                    unique case (in_kind)
                        KIND_CLEAR:
                        begin
                            used_next      = '0;
                            append_next    = 32'd0;
                            out_valid_next = 1'b1;
                        end
                        KIND_LOAD:
                        begin
                            off_next       = load_off;
                            out_valid_next = 1'b1;
                            if (drop)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                used_next   = used_reg + UW'(1);
                                append_next = (descriptor_count == ALL_ONES32)
                                              ? load_off : load_off + descriptor_count;
                            end
                        end
                        KIND_QUERY:
                        begin
                            inject_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // query leaves the last cell: exact match beats all-stages match
                if (chain_active[TABLE_DEPTH])
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (chain_tok[TABLE_DEPTH].ex_hit)
                    begin
                        found_next = 1'b1;
                        owner_next = chain_tok[TABLE_DEPTH].ex_owner;
                        off_next   = chain_tok[TABLE_DEPTH].ex_off;
                    end
                    else if (chain_tok[TABLE_DEPTH].al_hit)
                    begin
                        found_next = 1'b1;
                        owner_next = chain_tok[TABLE_DEPTH].al_owner;
                        off_next   = chain_tok[TABLE_DEPTH].al_off;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            append_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
            inject_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            append_reg    <= append_next;
            out_valid_reg <= out_valid_next;
            inject_reg    <= inject_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        full_reg  <= full_next;
        owner_reg <= owner_next;
        off_reg   <= off_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign table_full  = full_reg;
    assign match_owner = owner_reg;
    assign desc_offset = off_reg;

`ifndef SYNTHESIS
    a_no_result_while_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid_reg && (state_reg == ST_SCAN)))
        else $error("result beat pending during scan");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");
    a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_kind == KIND_QUERY)) |=> (state_reg == ST_SCAN) && inject_reg)
        else $error("query beat did not start a scan");
    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_active[TABLE_DEPTH] |-> (state_reg == ST_SCAN))
        else $error("query left chain outside scan");
`endif

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// tb_top: self-checking bench for descriptor_range_lookup
// depends on dru_pkg and the descriptor_range_lookup rtl
`default_nettype none
module tb_top;
    import dru_pkg::*;

    localparam int DEPTH      = 256;
    localparam int QUERY_LAT  = DEPTH + 2;
    localparam int CYCLE_CAP  = 4_000_000;

    typedef struct packed {
        logic        found;
        logic        full;
        logic [5:0]  owner;
        logic [31:0] offset;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = KIND_CLEAR;
    logic        new_table = 1'b0;
    logic [5:0]  owner_index = '0;
    logic [2:0]  visibility = '0;
    logic [1:0]  range_kind = '0;
    logic [31:0] register_number = '0;
    logic [31:0] reg_space = '0;
    logic [31:0] descriptor_count = '0;
    logic [31:0] table_offset_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic        table_full;
    logic [5:0]  match_owner;
    logic [31:0] desc_offset;

    descriptor_range_lookup dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .new_table(new_table), .owner_index(owner_index),
        .visibility(visibility), .range_kind(range_kind),
        .register_number(register_number), .reg_space(reg_space),
        .descriptor_count(descriptor_count), .table_offset_in(table_offset_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .table_full(table_full),
        .match_owner(match_owner), .desc_offset(desc_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the range table
    entry_t      shadow_tab [DEPTH];
    int unsigned shadow_used;
    logic [31:0] shadow_append;

    answer_t     pending_answers [$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    bit          quiet_mode;   // no idling on either side while set

    // recent loads, reused to build queries that hit
    entry_t      recent [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic answer_t predict_range_lookup(
        input logic [1:0] k, input logic nt, input logic [5:0] own,
        input logic [2:0] vis, input logic [1:0] rk, input logic [31:0] rg,
        input logic [31:0] sp, input logic [31:0] cnt, input logic [31:0] toff);
        answer_t     a;
        logic [31:0] start_off;
        logic [31:0] rel;
        logic [2:0]  want;
        a = '0;
        case (k)
            KIND_CLEAR:
            begin
                shadow_used = 0;
                shadow_append = '0;
            end
            KIND_LOAD:
            begin
                start_off = nt ? 32'd0 : shadow_append;
                a.offset = (toff == ALL_ONES32) ? start_off : toff;
                // owner is 6 bits so it can never exceed the 64 owners
                if (shadow_used >= DEPTH)
                    a.full = 1'b1;
                else
                begin
                    shadow_tab[shadow_used] = '{owner: own, vis: vis, rkind: rk,
                        base: rg, space: sp, count: cnt, offset: a.offset};
                    shadow_used++;
                    shadow_append = (cnt != ALL_ONES32) ? a.offset + cnt : a.offset;
                end
            end
            KIND_QUERY:
            begin
                // exact visibility first, then all-stage ranges
                for (int pass = 0; pass < 2 && !a.found; pass++)
                begin
                    want = (pass == 0) ? vis : VIS_ALL;
                    for (int i = 0; i < shadow_used && !a.found; i++)
                    begin
                        rel = rg - shadow_tab[i].base;
                        if (shadow_tab[i].vis == want && shadow_tab[i].rkind == rk
                            && shadow_tab[i].space == sp && rg >= shadow_tab[i].base
                            && (shadow_tab[i].count == ALL_ONES32
                                || rel < shadow_tab[i].count))
                        begin
                            a.found = 1'b1;
                            a.owner = shadow_tab[i].owner;
                            a.offset = shadow_tab[i].offset + rel;
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // send one beat, with a random gap in front of it
    // valid stays high from one beat to the next unless a gap is taken
    task automatic send_item(input logic [1:0] k, input logic nt, input logic [5:0] own,
                             input logic [2:0] vis, input logic [1:0] rk,
                             input logic [31:0] rg, input logic [31:0] sp,
                             input logic [31:0] cnt, input logic [31:0] toff);
        entry_t e;
        while (!quiet_mode && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        kind <= k; new_table <= nt; owner_index <= own; visibility <= vis;
        range_kind <= rk; register_number <= rg; reg_space <= sp;
        descriptor_count <= cnt; table_offset_in <= toff;
        in_valid <= 1'b1;
        pending_answers.insert(pending_answers.size(),
            predict_range_lookup(k, nt, own, vis, rk, rg, sp, cnt, toff));
        if (k == KIND_LOAD)
        begin
            e = '{owner: own, vis: vis, rkind: rk, base: rg, space: sp,
                  count: cnt, offset: toff};
            recent.insert(recent.size(), e);
            if (recent.size() > 32)
                void'(recent.pop_front());
        end
        do @(posedge clk); while (!in_ready);
    endtask

    // result side: random stalls, compare each beat to the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("unexpected result beat at cycle %0d", cycle_count);
                    error_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (found !== want.found)
                        report_mismatch("found", {31'd0, found}, {31'd0, want.found});
                    if (table_full !== want.full)
                        report_mismatch("table_full", {31'd0, table_full},
                                        {31'd0, want.full});
                    if (match_owner !== want.owner)
                        report_mismatch("match_owner", {26'd0, match_owner},
                                        {26'd0, want.owner});
                    if (desc_offset !== want.offset)
                        report_mismatch("desc_offset", desc_offset, want.offset);
                end
            end
            out_ready <= quiet_mode || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_answers.size() != 0);
    endtask

    function automatic logic [31:0] rand32();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return ALL_ONES32;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_clear();
        send_item(KIND_CLEAR, 1'($urandom), 6'($urandom), 3'($urandom), 2'($urandom),
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic send_load(input logic nt, input logic [5:0] own, input logic [2:0] vis,
                             input logic [1:0] rk, input logic [31:0] rg,
                             input logic [31:0] sp, input logic [31:0] cnt,
                             input logic [31:0] toff);
        send_item(KIND_LOAD, nt, own, vis, rk, rg, sp, cnt, toff);
    endtask

    task automatic send_query(input logic [2:0] vis, input logic [1:0] rk,
                              input logic [31:0] rg, input logic [31:0] sp);
        send_item(KIND_QUERY, 1'($urandom), 6'($urandom), vis, rk, rg, sp,
                  $urandom, $urandom);
    endtask

    // directed: append chain, unbounded count, wrap, exact vs all, unused kind
    task automatic test_directed();
        send_clear();
        send_query(3'd1, 2'd0, 32'd0, 32'd0);                 // empty table miss
        send_load(1'b1, 6'd0, VIS_ALL, 2'd0, 32'd0, 32'd0, 32'd4, ALL_ONES32);
        send_load(1'b0, 6'd1, 3'd2, 2'd0, 32'd0, 32'd0, 32'd8, ALL_ONES32);
        send_load(1'b1, 6'd63, 3'd7, 2'd3, ALL_ONES32, ALL_ONES32, ALL_ONES32, ALL_ONES32);
        send_load(1'b0, 6'd5, 3'd4, 2'd1, 32'd10, 32'd3, ALL_ONES32, 32'hFFFF_FFF0);
        send_load(1'b0, 6'd6, 3'd5, 2'd2, 32'd0, 32'd1, 32'd16, 32'hFFFF_FFFE);
        send_query(3'd2, 2'd0, 32'd3, 32'd0);                 // exact beats all
        send_query(3'd3, 2'd0, 32'd3, 32'd0);                 // falls back to all
        send_query(3'd3, 2'd0, 32'd4, 32'd0);                 // past the window
        send_query(3'd7, 2'd3, ALL_ONES32, ALL_ONES32);
        send_query(3'd4, 2'd1, ALL_ONES32, 32'd3);            // unbounded, wraps
        send_query(3'd4, 2'd1, 32'd9, 32'd3);                 // below base
        send_query(3'd5, 2'd2, 32'd15, 32'd1);                // offset wraps
        send_item(KIND_NONE, 1'b1, 6'd63, 3'd7, 2'd3, ALL_ONES32, ALL_ONES32,
                  ALL_ONES32, ALL_ONES32);
        send_query(3'd0, 2'd0, 32'd2, 32'd0);
        send_clear();
        send_query(3'd2, 2'd0, 32'd3, 32'd0);                 // gone after clear
    endtask

    // fill the table past its depth so later loads are dropped
    task automatic test_full_table();
        send_clear();
        for (int i = 0; i < DEPTH + 3; i++)
            send_load($urandom_range(7) == 0, i[5:0], 3'($urandom), 2'($urandom),
                      32'(i), 32'd9, $urandom_range(4), ALL_ONES32);
        send_query(3'd0, 2'd1, 32'd200, 32'd9);
        send_query(3'($urandom), 2'($urandom), 32'd255, 32'd9);
    endtask

    // well-formed parameter lists with queries aimed at them, plus noise
    task automatic test_random(input int items);
        int     sent;
        entry_t e;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(19) == 0 || shadow_used > DEPTH - 8)
                send_clear();
            else if ($urandom_range(9) < 4)
            begin
                e.owner = 6'($urandom);
                send_load($urandom_range(3) == 0, e.owner, 3'($urandom),
                          2'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? rand32() : $urandom_range(40),
                          ($urandom_range(3) == 0) ? rand32() : $urandom_range(2),
                          ($urandom_range(5) == 0) ? ALL_ONES32 : rand32(),
                          ($urandom_range(1) == 0) ? ALL_ONES32 : rand32());
            end
            else if ($urandom_range(9) < 7 && recent.size() > 0)
            begin
                e = recent[$urandom_range(recent.size() - 1)];
                send_query(($urandom_range(2) == 0) ? 3'($urandom) : e.vis, e.rkind,
                           e.base + $urandom_range(6) - 1, e.space);
            end
            else if ($urandom_range(19) == 0)
                send_item(KIND_NONE, 1'($urandom), 6'($urandom), 3'($urandom),
                          2'($urandom), rand32(), rand32(), rand32(), rand32());
            else
                send_query(3'($urandom), 2'($urandom), rand32(), rand32());
            sent++;
        end
    endtask

    initial
    begin
        shadow_used = 0;
        shadow_append = '0;
        quiet_mode = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random(600);
        // let everything drain before carrying on
        wait_drained();
        quiet_mode = 1'b1;
        test_random(200);
        quiet_mode = 1'b0;
        test_random(450);

        wait_drained();
        repeat (QUERY_LAT + 10) @(posedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
hdl/dru_pkg.sv
hdl/dru_cell.sv
hdl/descriptor_range_lookup.sv
bench/tb_top.sv
